FILE: sv/sae_pkg.sv
// Shared types and constants for the stack allocator engine.
// Depends on nothing; the other files that use it refer to it by scoped names.
package sae_pkg;

    // Fixed arena limits.
    localparam logic [31:0] ARENA_BYTES  = 32'd65536;
    localparam logic [17:0] HEADER_BYTES = 18'd8;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_NULL_FREE_OK = 1'b1;
    localparam int CFG_DATA_W = 17;
    localparam logic [16:0] CAPACITY_RESET = 17'h10000;

    // Request kinds.
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] request_bytes;
        logic [3:0]  align_log2;
        logic [15:0] free_offset;
    } in_word_t;

    typedef struct packed {
        logic [15:0] block_offset;
        logic [1:0]  status;
        logic [16:0] used_bytes;
        logic [16:0] remaining_bytes;
    } out_word_t;

    // Operation applied to the size stack.
    typedef struct packed {
        logic        push;
        logic        pop;
        logic        clear;
        logic [16:0] push_size;
    } stack_op_t;

endpackage

FILE: sv/sae_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sae_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/sae_stack.sv
// Stack of block sizes: the top entry sits in a register, the rest in a RAM.
// Depends on sae_pkg and sae_ram.
module sae_stack #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sae_pkg::stack_op_t op,
    output logic [$clog2(MAX_BLOCKS+1)-1:0] count,
    output logic [16:0]        top_size
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = $clog2(MAX_BLOCKS);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [16:0]      top_size_reg, top_size_next;
    logic             fwd_valid_reg, fwd_valid_next;
    logic [16:0]      fwd_data_reg;
    logic [CNT_W-1:0] cnt_minus1, next_minus2;
    logic [IDX_W-1:0] waddr, raddr;
    logic             we;
    logic [16:0]      rdata, second;

    always_comb
    begin
        if (op.clear)
        begin
            count_next = '0;
        end
        else if (op.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (op.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // On a push the old top moves down into the RAM.
    assign cnt_minus1  = count_reg - CNT_W'(1);
    assign waddr       = cnt_minus1[IDX_W-1:0];
    assign we          = op.push && (count_reg != '0);

    // The RAM is always addressed at the entry just below the next top, so its
    // data is ready for a pop in the following cycle.
    assign next_minus2 = count_next - CNT_W'(2);
    assign raddr       = next_minus2[IDX_W-1:0];

    assign fwd_valid_next = we && (waddr == raddr);
    assign second         = fwd_valid_reg ? fwd_data_reg : rdata;

    always_comb
    begin
        if (op.push)
        begin
            top_size_next = op.push_size;
        end
        else if (op.pop)
        begin
            top_size_next = second;
        end
        else
        begin
            top_size_next = top_size_reg;
        end
    end

    sae_ram #(
        .WIDTH (17),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (top_size_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_size_reg <= top_size_next;
        fwd_data_reg <= top_size_reg;
    end

    assign count    = count_reg;
    assign top_size = top_size_reg;

endmodule

FILE: sv/stack_allocator_engine.sv
// LIFO bump allocator over a configurable arena.
// Depends on sae_pkg and sae_stack.
//
// Usage:
//   Requests arrive as words on in_valid/in_stall/in_word: allocate, free or
//   reset the arena. Each request gives exactly one result word on
//   out_valid/out_stall/out_word carrying the payload offset, a status code
//   and the used and remaining byte counts after that request.
//   A word accepted into the input register is worked on once the result
//   register is empty or the receiver does not stall; its result is then
//   registered and offered on out_word. One request is taken every cycle
//   while the receiver does not stall; the stack keeps pace with successive pops
//   because its RAM is always read just below the top entry, kept in a register.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; a further input word is then stalled.
//   The configuration port writes capacity_bytes (index 0, which also empties
//   the arena) or the null-free flag (index 1); write only while idle.
//   Reset empties the stack, sets the capacity to 65536 and clears both
//   handshake stages.
module stack_allocator_engine #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [sae_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sae_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  sae_pkg::in_word_t                   in_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output sae_pkg::out_word_t                  out_word
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [16:0]          capacity_reg;
    logic                 null_free_ok_reg;
    logic                 in_valid_reg;
    sae_pkg::in_word_t    in_reg;
    logic                 out_valid_reg;
    sae_pkg::out_word_t   out_reg, out_next;
    logic [16:0]          top_offset_reg, top_offset_next;

    logic                 proc_go;
    logic                 take_in;
    logic [16:0]          cap;
    sae_pkg::stack_op_t   op;
    logic [CNT_W-1:0]     count;
    logic [16:0]          top_size;

    logic [17:0]          raw_size, align_mask, size;
    logic [18:0]          end_offset;
    logic [17:0]          hdr_end;
    logic [17:0]          free_base;
    logic [15:0]          offset;
    logic [1:0]           status;

    assign proc_go  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign take_in  = !in_valid_reg || proc_go;
    assign in_stall = !take_in;

    assign cap = (32'(capacity_reg) > sae_pkg::ARENA_BYTES) ?
                 sae_pkg::ARENA_BYTES[16:0] : capacity_reg;

    // Header plus payload, rounded up to the alignment.
    assign raw_size   = sae_pkg::HEADER_BYTES + 18'(in_reg.request_bytes);
    assign align_mask = (18'd1 << in_reg.align_log2) - 18'd1;
    assign size       = (raw_size + align_mask) & ~align_mask;
    assign end_offset = 19'(top_offset_reg) + 19'(size);
    assign hdr_end    = 18'(top_offset_reg) + sae_pkg::HEADER_BYTES;
    assign free_base  = 18'(top_offset_reg) - 18'(top_size) + sae_pkg::HEADER_BYTES;

    always_comb
    begin
        op              = '0;
        op.push_size    = size[16:0];
        offset          = '0;
        status          = sae_pkg::ST_OK;
        top_offset_next = top_offset_reg;
        case (in_reg.kind)
            sae_pkg::KIND_ALLOC:
            begin
                if ((end_offset > 19'(cap)) || (hdr_end > 18'hFFFF))
                begin
                    status = sae_pkg::ST_NOSPACE;
                end
                else if (count >= CNT_W'(MAX_BLOCKS))
                begin
                    status = sae_pkg::ST_FULL;
                end
                else
                begin
                    op.push         = 1'b1;
                    offset          = hdr_end[15:0];
                    top_offset_next = end_offset[16:0];
                end
            end
            sae_pkg::KIND_FREE:
            begin
                if (in_reg.free_offset == '0)
                begin
                    status = null_free_ok_reg ? sae_pkg::ST_OK : sae_pkg::ST_BADFREE;
                end
                else if (count == '0)
                begin
                    status = sae_pkg::ST_BADFREE;
                end
                else if ((top_size > top_offset_reg) ||
                         (free_base != 18'(in_reg.free_offset)))
                begin
                    status = sae_pkg::ST_BADFREE;
                end
                else
                begin
                    op.pop          = 1'b1;
                    top_offset_next = top_offset_reg - top_size;
                end
            end
            sae_pkg::KIND_RESET:
            begin
                op.clear        = 1'b1;
                top_offset_next = '0;
            end
            default:
            begin
                status = sae_pkg::ST_OK;
            end
        endcase

        if (!proc_go)
        begin
            op.push         = 1'b0;
            op.pop          = 1'b0;
            op.clear        = 1'b0;
            top_offset_next = top_offset_reg;
        end
        // Writing the capacity re-initialises the arena.
        if (cfg_write && (cfg_index == sae_pkg::REG_CAPACITY))
        begin
            op.clear        = 1'b1;
            top_offset_next = '0;
        end

        out_next.block_offset    = offset;
        out_next.status          = status;
        out_next.used_bytes      = top_offset_next;
        out_next.remaining_bytes = (cap > top_offset_next) ? (cap - top_offset_next) : '0;
    end

    sae_stack #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .count    (count),
        .top_size (top_size)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg     <= sae_pkg::CAPACITY_RESET;
            null_free_ok_reg <= 1'b0;
            top_offset_reg   <= '0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == sae_pkg::REG_CAPACITY))
            begin
                capacity_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == sae_pkg::REG_NULL_FREE_OK))
            begin
                null_free_ok_reg <= cfg_data[0];
            end
            top_offset_reg <= top_offset_next;
            if (take_in)
            begin
                in_valid_reg <= in_valid;
            end
            if (proc_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in && in_valid)
        begin
            in_reg <= in_word;
        end
        if (proc_go)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule
